[design/latr_pkg.sv]
// latr_pkg: shared types and constants for the limit alarm trap queue
// holds the command/result transaction structs, configuration register indexes and command codes
// no dependencies
package latr_pkg;

	localparam int CMD_W      = 3;
	localparam int DEV_W      = 6;
	localparam int COL_W      = 3;
	localparam int VAL_W      = 32;
	localparam int LEVEL_W    = 5;
	localparam int FIFO_W     = DEV_W + COL_W;
	localparam int LIMIT_REGS = 3;
	localparam int MASK_W     = 2 * LIMIT_REGS;
	localparam int TICKS_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int DEV_ROWS   = 1 << DEV_W;

	// command codes
	localparam logic [CMD_W-1:0] CMD_TICK   = CMD_W'(0);
	localparam logic [CMD_W-1:0] CMD_SWEEP  = CMD_W'(1);
	localparam logic [CMD_W-1:0] CMD_SAMPLE = CMD_W'(2);
	localparam logic [CMD_W-1:0] CMD_NOTIFY = CMD_W'(3);
	localparam logic [CMD_W-1:0] CMD_POP    = CMD_W'(4);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS0  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS1  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LIMITS2  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_WATCH    = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_TRAPS_OFF = CFG_IDX_W'(5);

	typedef struct packed {
		logic [CMD_W-1:0]        cmd;
		logic [DEV_W-1:0]        dev_index;
		logic [COL_W-1:0]        col_index;
		logic signed [VAL_W-1:0] sample_value;
		logic                    dev_enabled;
	} cmd_item_t;

	typedef struct packed {
		logic               trap_valid;
		logic [DEV_W-1:0]   trap_dev;
		logic [COL_W-1:0]   trap_col;
		logic               out_of_limit;
		logic               enqueued;
		logic               dropped;
		logic [LEVEL_W-1:0] queue_level;
	} res_item_t;

	typedef struct packed {
		logic [LIMIT_REGS-1:0][CFG_DATA_W-1:0] limits;
		logic [MASK_W-1:0]                     watch_mask;
		logic [TICKS_W-1:0]                    repeat_ticks;
		logic                                  traps_off;
	} cfg_t;

endpackage

[design/latr_ram.sv]
// latr_ram: generic single write port ram with registered read
// no package dependencies
module latr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/latr_cfg_regs.sv]
// latr_cfg_regs: configuration register file of the limit alarm trap queue
// depends on latr_pkg for the register indexes and the cfg_t struct
module latr_cfg_regs import latr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			unique case (index)
				REG_LIMITS0:   cfg_q.limits[0]    <= data;
				REG_LIMITS1:   cfg_q.limits[1]    <= data;
				REG_LIMITS2:   cfg_q.limits[2]    <= data;
				REG_WATCH:     cfg_q.watch_mask   <= data[MASK_W-1:0];
				REG_REPEAT:    cfg_q.repeat_ticks <= data[TICKS_W-1:0];
				REG_TRAPS_OFF: cfg_q.traps_off    <= data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/limit_alarm_trap_queue.sv]
// limit alarm trap queue: an accepted command is held in the input register, and its result
// transaction is written from there into the result register
// throughput one transaction per cycle while the result side does not stall, set by the
// read-modify-write of the out-of-limit row and the queue pointers behind one input register;
// a held result backs up the input only once the input register is occupied as well
// reset clears control, config, pointers, countdown and the per-row valid flops, so the
// out-of-limit rows read as zero at once with no clearing pass; queue slots stay undefined
// until written
module limit_alarm_trap_queue import latr_pkg::*; #(
	parameter int DEVICES     = 64,
	parameter int COLS        = 3,
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  cmd_item_t             cmd_item,
	output logic                  res_valid,
	input  logic                  res_stall,
	output res_item_t             res_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// rows reachable through the device field
	localparam int ROWS = (DEVICES < DEV_ROWS) ? DEVICES : DEV_ROWS;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW   = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int PW   = $clog2(QUEUE_DEPTH);

	cfg_t cfg;

	// input register and its bypass captures
	logic             valid_s1;
	cmd_item_t        item_s1;
	logic             row_byp_s1;
	logic [COLS-1:0]  row_byp_data_s1;
	logic             fifo_byp_s1;
	logic [FIFO_W-1:0] fifo_byp_data_s1;

	// block state
	logic [ROWS-1:0]    row_vld_q;
	logic [PW-1:0]      head_q, tail_q;
	logic [TICKS_W-1:0] cd_q;
	logic               rnow_q;

	// result register
	logic      res_valid_q;
	res_item_t res_item_q;

	// handshake
	logic res_free, load, fire;

	// ram ports
	logic [COLS-1:0]   row_rd;
	logic [FIFO_W-1:0] fifo_rd;

	// evaluation of the item in the input register
	logic              in_range;
	logic [RAW-1:0]    row_idx;
	logic [CW-1:0]     col_idx;
	logic [COLS-1:0]   row_cur;
	logic [COLS-1:0]   col_bit;
	logic              was_out;
	logic              has_lim, lo_en, hi_en, breach;
	logic [CFG_DATA_W-1:0] lim;
	logic signed [VAL_W-1:0] lo_lim, hi_lim;
	logic [FIFO_W-1:0] fifo_cur;
	logic              row_we;
	logic [COLS-1:0]   row_wdata;
	logic              push_req, push_ok, drop, ool, t_valid, full;
	logic [PW-1:0]     head_inc, tail_inc, head_d, tail_d, lvl;
	logic [PW+LEVEL_W-1:0] lvl_ext;
	logic [TICKS_W-1:0] cd_d;
	logic              rnow_d;
	res_item_t         res_item_d;

	latr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// the input register moves on whenever the result register is free or being emptied
	assign res_free  = !res_valid_q || !res_stall;
	assign cmd_stall = valid_s1 && !res_free;
	assign load      = cmd_valid && !cmd_stall;
	assign fire      = valid_s1 && res_free;

	// out-of-limit rows, one word of COLS bits per device
	latr_ram #(
		.WIDTH (COLS),
		.DEPTH (ROWS)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_idx),
		.wdata (row_wdata),
		.re    (load),
		.raddr (cmd_item.dev_index[RAW-1:0]),
		.rdata (row_rd)
	);

	// trap ring, read ahead at the tail that holds once the current item is done
	latr_ram #(
		.WIDTH (FIFO_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (head_q),
		.wdata ({item_s1.dev_index, item_s1.col_index}),
		.re    (load),
		.raddr (tail_d),
		.rdata (fifo_rd)
	);

	// row and column decode of the held item
	assign in_range = ({{(9 - DEV_W){1'b0}}, item_s1.dev_index} < 9'(DEVICES))
		&& ({1'b0, item_s1.col_index} < 4'(COLS));
	assign row_idx = item_s1.dev_index[RAW-1:0];
	assign col_idx = item_s1.col_index[CW-1:0];
	assign col_bit = COLS'(1) << col_idx;

	// a write in the same edge as the read is forwarded, an unwritten row reads as zero
	assign row_cur  = row_byp_s1 ? row_byp_data_s1 : (row_vld_q[row_idx] ? row_rd : '0);
	assign was_out  = row_cur[col_idx];
	assign fifo_cur = fifo_byp_s1 ? fifo_byp_data_s1 : fifo_rd;

	// window comparison, only the first columns carry limits
	assign has_lim = item_s1.col_index < COL_W'(LIMIT_REGS);
	assign lim     = has_lim ? cfg.limits[item_s1.col_index[1:0]] : '0;
	assign lo_lim  = signed'(lim[VAL_W-1:0]);
	assign hi_lim  = signed'(lim[CFG_DATA_W-1:VAL_W]);
	assign lo_en   = has_lim && cfg.watch_mask[{item_s1.col_index[1:0], 1'b0}];
	assign hi_en   = has_lim && cfg.watch_mask[{item_s1.col_index[1:0], 1'b1}];
	assign breach  = (lo_en && (item_s1.sample_value < lo_lim))
		|| (hi_en && (item_s1.sample_value > hi_lim));

	// ring pointers, full when one slot is left
	assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign full     = head_inc == tail_q;

	always_comb begin
		row_we    = 1'b0;
		row_wdata = row_cur;
		push_req  = 1'b0;
		ool       = 1'b0;
		t_valid   = 1'b0;
		tail_d    = tail_q;
		cd_d      = cd_q;
		rnow_d    = rnow_q;
		if (fire) begin
			unique case (item_s1.cmd)
				CMD_TICK: begin
					if (cd_q != '0) begin
						cd_d = cd_q - 1'b1;
					end
				end
				CMD_SWEEP: begin
					// a repeat round opens only when the countdown has run out
					if ((cfg.repeat_ticks != '0) && (cd_q == '0)) begin
						rnow_d = 1'b1;
						cd_d   = cfg.repeat_ticks;
					end else begin
						rnow_d = 1'b0;
					end
				end
				CMD_SAMPLE: begin
					if (in_range) begin
						row_we = 1'b1;
						if (!item_s1.dev_enabled) begin
							// disabled device wipes its whole row
							row_wdata = '0;
						end else if (breach) begin
							ool       = 1'b1;
							row_wdata = row_cur | col_bit;
							push_req  = !was_out || rnow_q;
						end else begin
							row_wdata = row_cur & ~col_bit;
						end
					end
				end
				CMD_NOTIFY: begin
					push_req = in_range;
				end
				CMD_POP: begin
					if (cfg.traps_off) begin
						tail_d = head_q;
					end else if (tail_q != head_q) begin
						t_valid = 1'b1;
						tail_d  = tail_inc;
					end
				end
				default: ;
			endcase
		end
		push_ok = push_req && !full;
		drop    = push_req && full;
		head_d  = push_ok ? head_inc : head_q;
	end

	// cells waiting once this item is done
	assign lvl     = head_d - tail_d + ((head_d < tail_d) ? PW'(QUEUE_DEPTH) : PW'(0));
	assign lvl_ext = {{LEVEL_W{1'b0}}, lvl};

	always_comb begin
		res_item_d              = '0;
		res_item_d.trap_valid   = t_valid;
		res_item_d.trap_dev     = t_valid ? fifo_cur[FIFO_W-1:COL_W] : '0;
		res_item_d.trap_col     = t_valid ? fifo_cur[COL_W-1:0] : '0;
		res_item_d.out_of_limit = ool;
		res_item_d.enqueued     = push_ok;
		res_item_d.dropped      = drop;
		res_item_d.queue_level  = lvl_ext[LEVEL_W-1:0];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			row_vld_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cd_q        <= '0;
			rnow_q      <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (row_we) begin
				row_vld_q[row_idx] <= 1'b1;
			end
			head_q <= head_d;
			tail_q <= tail_d;
			cd_q   <= cd_d;
			rnow_q <= rnow_d;
		end
	end

	// payload registers, bypass captured with the ram reads
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1          <= cmd_item;
			row_byp_s1       <= row_we && (row_idx == cmd_item.dev_index[RAW-1:0]);
			row_byp_data_s1  <= row_wdata;
			fifo_byp_s1      <= push_ok && (head_q == tail_d);
			fifo_byp_data_s1 <= {item_s1.dev_index, item_s1.col_index};
		end
		if (fire) begin
			res_item_q <= res_item_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

[design/latr_checker.sv]
// latr_checker: port-level assertions for the limit alarm trap queue
// depends on latr_pkg; bound to limit_alarm_trap_queue at the end of this file
module latr_checker import latr_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("held result changed");

	// the input side only backs up behind a held result
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> res_valid && res_stall)
		else $error("input stalled with result side free");

	// a pop result never also queues, drops or flags a breach
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.trap_valid |->
			!res_item.enqueued && !res_item.dropped && !res_item.out_of_limit)
		else $error("pop result carries sample flags");

	// a drop only happens on a full ring
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.dropped |->
			!res_item.enqueued && (res_item.queue_level == LEVEL_W'(QUEUE_DEPTH - 1)))
		else $error("drop reported with room in the ring");

endmodule

bind limit_alarm_trap_queue latr_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);

[sim/tb_limit_alarm_trap_queue.sv]
`timescale 1ns / 1ps
// tb_limit_alarm_trap_queue: self-checking bench for the limit alarm trap queue
// depends on latr_pkg and limit_alarm_trap_queue; drives a directed vector list, then random
// command streams under several limit settings, each checked against a cycle-free alarm model
module tb_limit_alarm_trap_queue;
	import latr_pkg::*;

	localparam int DEVICES     = 64;
	localparam int COLS        = 3;
	localparam int QUEUE_DEPTH = 32;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 4;
	localparam int IDLE_PCT      = 24;
	localparam int SETTLE_CYCLES = 6;
	localparam int STUCK_LIMIT   = 2000;
	localparam int PHASE_ITEMS   = 75;
	localparam int PHASES        = 6;
	localparam int SHOWN_ERRORS  = 10;

	localparam logic [VAL_W-1:0] INT_MIN = 32'h8000_0000;
	localparam logic [VAL_W-1:0] INT_MAX = 32'h7FFF_FFFF;

	// spare command codes, the block must leave its state alone on these
	localparam logic [CMD_W-1:0] CMD_RSVD5 = CMD_W'(5);
	localparam logic [CMD_W-1:0] CMD_RSVD6 = CMD_W'(6);
	localparam logic [CMD_W-1:0] CMD_RSVD7 = CMD_W'(7);

	typedef struct {
		cmd_item_t item;
		logic      typed;
		res_item_t want;
		logic      reload;
	} vector_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	cmd_item_t             cmd_item;
	logic                  res_valid;
	logic                  res_stall;
	res_item_t             res_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// hand-typed expectation travelling alongside the current command
	logic      want_typed = 1'b0;
	res_item_t want_res   = '0;

	// no idling on either side while this is set
	logic steady = 1'b0;

	// alarm model: configuration copy
	logic [CFG_DATA_W-1:0] lim_r [LIMIT_REGS];
	logic [MASK_W-1:0]     mask_r;
	logic [TICKS_W-1:0]    rep_ticks_r;
	logic                  toff_r;

	// alarm model: state
	logic [COLS-1:0]   outside_r [DEVICES];
	logic [FIFO_W-1:0] trap_slot [QUEUE_DEPTH];
	logic [PTR_W-1:0]  head_r;
	logic [PTR_W-1:0]  tail_r;
	logic [TICKS_W-1:0] countdown_r;
	logic              rearm_r;

	res_item_t verdict_q [$];
	vector_t   directed_rows [$];

	int mismatches    = 0;
	int stuck_cycles  = 0;
	int n_commands    = 0;
	int n_samples     = 0;
	int n_outside     = 0;
	int n_queued      = 0;
	int n_dropped     = 0;
	int n_delivered   = 0;
	int n_drained     = 0;

	limit_alarm_trap_queue #(
		.DEVICES(DEVICES),
		.COLS(COLS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_item(cmd_item),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_item(res_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_HALF) clk = ~clk;

	// ---------------------------------------------------------------------------------------
	// alarm model
	// ---------------------------------------------------------------------------------------

	// window check for one column, each side enabled on its own
	function automatic logic breached(input logic [COL_W-1:0] c,
			input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		if (c >= LIMIT_REGS)
			return 1'b0;
		lo = lim_r[c][31:0];
		hi = lim_r[c][63:32];
		return (mask_r[2*c] && v < lo) || (mask_r[2*c+1] && v > hi);
	endfunction

	// ring holds at most depth-1 cells, full when the head would run into the tail
	function automatic logic enqueue_cell(input logic [DEV_W-1:0] dev,
			input logic [COL_W-1:0] col);
		logic [PTR_W-1:0] nxt;
		nxt = head_r + 1'b1;
		if (nxt == tail_r)
			return 1'b0;
		trap_slot[head_r] = {dev, col};
		head_r = nxt;
		return 1'b1;
	endfunction

	function automatic res_item_t compute_verdict(input cmd_item_t it);
		res_item_t       r;
		logic [COLS-1:0] bit_mask;
		logic            was_out;
		r = '0;
		case (it.cmd)
			CMD_TICK: begin
				// countdown saturates at zero
				if (countdown_r != 0)
					countdown_r = countdown_r - 1'b1;
			end
			CMD_SWEEP: begin
				if (rep_ticks_r != 0 && countdown_r == 0) begin
					rearm_r     = 1'b1;
					countdown_r = rep_ticks_r;
				end else begin
					rearm_r = 1'b0;
				end
			end
			CMD_SAMPLE: begin
				if (it.col_index < COLS) begin
					if (!it.dev_enabled) begin
						// a disabled device wipes its whole row
						outside_r[it.dev_index] = '0;
					end else begin
						bit_mask = COLS'(1) << it.col_index;
						was_out  = |(outside_r[it.dev_index] & bit_mask);
						if (!breached(it.col_index, it.sample_value)) begin
							outside_r[it.dev_index] &= ~bit_mask;
						end else begin
							r.out_of_limit = 1'b1;
							if (!was_out || rearm_r) begin
								if (enqueue_cell(it.dev_index, it.col_index))
									r.enqueued = 1'b1;
								else
									r.dropped = 1'b1;
							end
							outside_r[it.dev_index] |= bit_mask;
						end
					end
				end
			end
			CMD_NOTIFY: begin
				if (it.col_index < COLS) begin
					if (enqueue_cell(it.dev_index, it.col_index))
						r.enqueued = 1'b1;
					else
						r.dropped = 1'b1;
				end
			end
			CMD_POP: begin
				if (toff_r) begin
					tail_r = head_r;
				end else if (tail_r != head_r) begin
					r.trap_valid           = 1'b1;
					{r.trap_dev, r.trap_col} = trap_slot[tail_r];
					tail_r                 = tail_r + 1'b1;
				end
			end
			default: ;
		endcase
		r.queue_level = LEVEL_W'(head_r - tail_r);
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------------------------

	function automatic cmd_item_t make_cmd(input logic [CMD_W-1:0] c, input int dev,
			input int col, input logic [VAL_W-1:0] v, input logic en);
		cmd_item_t it;
		it.cmd          = c;
		it.dev_index    = DEV_W'(dev);
		it.col_index    = COL_W'(col);
		it.sample_value = v;
		it.dev_enabled  = en;
		return it;
	endfunction

	function automatic res_item_t verdict(input logic tv, input int dev, input int col,
			input logic ool, input logic enq, input logic drop, input int lvl);
		res_item_t r;
		r.trap_valid   = tv;
		r.trap_dev     = DEV_W'(dev);
		r.trap_col     = COL_W'(col);
		r.out_of_limit = ool;
		r.enqueued     = enq;
		r.dropped      = drop;
		r.queue_level  = LEVEL_W'(lvl);
		return r;
	endfunction

	function automatic void add_row(input cmd_item_t it, input logic typed,
			input res_item_t want, input logic reload);
		vector_t row;
		row.item   = it;
		row.typed  = typed;
		row.want   = want;
		row.reload = reload;
		directed_rows.push_back(row);
	endfunction

	// random window somewhere around zero, low never above high
	function automatic logic [CFG_DATA_W-1:0] rand_window();
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		lo = int'($urandom_range(600)) - 300;
		hi = lo + int'($urandom_range(400));
		return {hi, lo};
	endfunction

	// samples on a handful of cells with values hugging the limits, so cells
	// keep crossing in and out; the mix of pops and notifies is set per phase
	function automatic cmd_item_t rand_command(input int pop_pct, input int notify_pct);
		cmd_item_t               it;
		int                      r;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		r = $urandom_range(99);
		it.dev_index = ($urandom_range(9) < 7) ? DEV_W'($urandom_range(3))
			: DEV_W'($urandom_range(DEVICES - 1));
		it.col_index = ($urandom_range(99) < 85) ? COL_W'($urandom_range(COLS - 1))
			: COL_W'($urandom_range(7, COLS));
		it.dev_enabled = ($urandom_range(99) < 92);
		if (it.col_index < LIMIT_REGS) begin
			lo = lim_r[it.col_index][31:0];
			hi = lim_r[it.col_index][63:32];
		end else begin
			lo = $urandom;
			hi = $urandom;
		end
		case ($urandom_range(9))
			0:       it.sample_value = INT_MIN;
			1:       it.sample_value = INT_MAX;
			2, 3:    it.sample_value = $urandom;
			default: it.sample_value = ($urandom_range(1) ? lo : hi) + int'($urandom_range(4)) - 2;
		endcase
		if (r < pop_pct)
			it.cmd = CMD_POP;
		else if (r < pop_pct + notify_pct)
			it.cmd = CMD_NOTIFY;
		else if (r < pop_pct + notify_pct + 8)
			it.cmd = CMD_TICK;
		else if (r < pop_pct + notify_pct + 14)
			it.cmd = CMD_SWEEP;
		else if (r < pop_pct + notify_pct + 17)
			it.cmd = CMD_W'($urandom_range(CMD_RSVD7, CMD_RSVD5));
		else
			it.cmd = CMD_SAMPLE;
		return it;
	endfunction

	// ---------------------------------------------------------------------------------------
	// driving, always entered and left on a falling edge
	// ---------------------------------------------------------------------------------------

	task automatic push_command(input cmd_item_t it, input logic typed, input res_item_t want);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid  <= 1'b1;
		cmd_item   <= it;
		want_typed <= typed;
		want_res   <= want;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold off the sender until every expected result is back and the pipe is empty
	task automatic settle();
		cmd_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		case (idx)
			REG_LIMITS0:   lim_r[0]    = d;
			REG_LIMITS1:   lim_r[1]    = d;
			REG_LIMITS2:   lim_r[2]    = d;
			REG_WATCH:     mask_r      = d[MASK_W-1:0];
			REG_REPEAT:    rep_ticks_r = d[TICKS_W-1:0];
			REG_TRAPS_OFF: toff_r      = d[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [CFG_DATA_W-1:0] l0, input logic [CFG_DATA_W-1:0] l1,
			input logic [CFG_DATA_W-1:0] l2, input logic [MASK_W-1:0] m,
			input logic [TICKS_W-1:0] rt, input logic toff);
		settle();
		write_reg(REG_LIMITS0, l0);
		write_reg(REG_LIMITS1, l1);
		write_reg(REG_LIMITS2, l2);
		write_reg(REG_WATCH, CFG_DATA_W'(m));
		write_reg(REG_REPEAT, CFG_DATA_W'(rt));
		write_reg(REG_TRAPS_OFF, CFG_DATA_W'(toff));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------------------------------
	// receiver back-pressure
	// ---------------------------------------------------------------------------------------

	always @(negedge clk)
		res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);

	// ---------------------------------------------------------------------------------------
	// monitor: check the oldest expectation, then predict for the newly accepted command
	// ---------------------------------------------------------------------------------------

	always @(posedge clk) begin
		res_item_t oldest;
		res_item_t fresh;
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (verdict_q.size() == 0) begin
					if (mismatches < SHOWN_ERRORS)
						$display("unexpected result transaction %h with nothing pending", res_item);
					mismatches++;
				end else begin
					oldest = verdict_q.pop_front();
					if (res_item.trap_valid !== oldest.trap_valid ||
							res_item.trap_dev !== oldest.trap_dev ||
							res_item.trap_col !== oldest.trap_col ||
							res_item.out_of_limit !== oldest.out_of_limit ||
							res_item.enqueued !== oldest.enqueued ||
							res_item.dropped !== oldest.dropped ||
							res_item.queue_level !== oldest.queue_level) begin
						if (mismatches < SHOWN_ERRORS) begin
							$display("mismatch: exp tv=%0b dev=%0d col=%0d ool=%0b enq=%0b drop=%0b lvl=%0d",
								oldest.trap_valid, oldest.trap_dev, oldest.trap_col,
								oldest.out_of_limit, oldest.enqueued, oldest.dropped,
								oldest.queue_level);
							$display("          got tv=%0b dev=%0d col=%0d ool=%0b enq=%0b drop=%0b lvl=%0d",
								res_item.trap_valid, res_item.trap_dev, res_item.trap_col,
								res_item.out_of_limit, res_item.enqueued, res_item.dropped,
								res_item.queue_level);
						end
						mismatches++;
					end
				end
			end
			if (cmd_valid && !cmd_stall) begin
				if (cmd_item.cmd == CMD_POP && toff_r)
					n_drained++;
				fresh = compute_verdict(cmd_item);
				verdict_q.push_back(want_typed ? want_res : fresh);
				n_commands++;
				if (cmd_item.cmd == CMD_SAMPLE)
					n_samples++;
				n_outside   += fresh.out_of_limit;
				n_queued    += fresh.enqueued;
				n_dropped   += fresh.dropped;
				n_delivered += fresh.trap_valid;
			end
		end
	end

	// watchdog: nothing moving on either channel for too long means a hang
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------------------

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_item  = '0;
		res_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		// model reset, matching the block's reset values
		foreach (lim_r[i])
			lim_r[i] = '0;
		mask_r      = '0;
		rep_ticks_r = '0;
		toff_r      = 1'b0;
		foreach (outside_r[i])
			outside_r[i] = '0;
		head_r      = '0;
		tail_r      = '0;
		countdown_r = '0;
		rearm_r     = 1'b0;

		// straight after reset, all registers zero so nothing is watched
		add_row(make_cmd(CMD_POP, 0, 0, 0, 1'b0), 1'b1, verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_TICK, 0, 0, 0, 1'b1), 1'b1, verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_SWEEP, 0, 0, 0, 1'b1), 1'b1, verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_RSVD5, 63, 7, INT_MAX, 1'b1), 1'b1,
			verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_RSVD7, 0, 0, INT_MIN, 1'b0), 1'b1,
			verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 5, 0, INT_MIN, 1'b1), 1'b1,
			verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_NOTIFY, 63, 2, 0, 1'b1), 1'b1, verdict(0, 0, 0, 0, 1, 0, 1), 1'b0);
		// column without a limits register: notify and sample both ignored
		add_row(make_cmd(CMD_NOTIFY, 0, 3, 0, 1'b1), 1'b1, verdict(0, 0, 0, 0, 0, 0, 1), 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 0, 7, INT_MAX, 1'b1), 1'b1,
			verdict(0, 0, 0, 0, 0, 0, 1), 1'b0);
		add_row(make_cmd(CMD_POP, 0, 0, 0, 1'b1), 1'b1, verdict(1, 63, 2, 0, 0, 0, 0), 1'b0);
		add_row(make_cmd(CMD_POP, 0, 0, 0, 1'b1), 1'b1, verdict(0, 0, 0, 0, 0, 0, 0), 1'b0);

		// windows loaded: fresh crossings, return inside, disabled row, a full-range window
		add_row(make_cmd(CMD_SAMPLE, 0, 0, 32'd101, 1'b1), 1'b0, '0, 1'b1);
		add_row(make_cmd(CMD_SAMPLE, 0, 0, 32'd0, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 0, 0, -32'sd101, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 0, 0, -32'sd101, 1'b0), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 0, 0, -32'sd101, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 63, 1, INT_MIN, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 63, 1, INT_MAX, 1'b1), 1'b0, '0, 1'b0);
		// repeat cadence: sweep arms, ticks run the countdown down, second sweep re-arms
		add_row(make_cmd(CMD_SAMPLE, 1, 2, 32'd1, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SWEEP, 0, 0, 0, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 1, 2, 32'd1, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_TICK, 0, 0, 0, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_TICK, 0, 0, 0, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SWEEP, 0, 0, 0, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_SAMPLE, 1, 2, -32'sd1, 1'b1), 1'b0, '0, 1'b0);
		add_row(make_cmd(CMD_POP, 0, 0, 0, 1'b1), 1'b0, '0, 1'b0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].reload)
				load_settings({32'sd100, -32'sd100}, {INT_MAX, INT_MIN}, '0, 6'h3F, 32'd2, 1'b0);
			push_command(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
		end

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			int pop_pct;
			int notify_pct;
			case (p)
				0: begin
					load_settings(rand_window(), rand_window(), rand_window(), 6'h3F, 32'd3, 1'b0);
					pop_pct    = 20;
					notify_pct = 5;
				end
				1: begin
					// queue fills and overflows, repeats off
					load_settings(rand_window(), rand_window(), rand_window(),
						MASK_W'($urandom_range(63)), 32'd0, 1'b0);
					pop_pct    = 3;
					notify_pct = 45;
				end
				2: begin
					// inverted windows: every enabled value is outside; pops drain silently
					load_settings({INT_MIN, INT_MAX}, {INT_MIN, INT_MAX}, {INT_MIN, INT_MAX},
						6'h3F, 32'hFFFF_FFFF, 1'b1);
					pop_pct    = 15;
					notify_pct = 20;
				end
				3: begin
					load_settings({INT_MAX, INT_MIN}, {INT_MAX, INT_MIN}, {INT_MAX, INT_MIN},
						6'h00, 32'd1, 1'b0);
					pop_pct    = 25;
					notify_pct = 15;
				end
				4: begin
					load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
						MASK_W'($urandom_range(63)), TICKS_W'($urandom_range(4, 1)), 1'b0);
					pop_pct    = 18;
					notify_pct = 10;
				end
				default: begin
					// back-to-back stretch, neither side idles
					load_settings(rand_window(), rand_window(), rand_window(), 6'h3F, 32'd2, 1'b0);
					steady     = 1'b1;
					pop_pct    = 22;
					notify_pct = 5;
				end
			endcase
			repeat (PHASE_ITEMS)
				push_command(rand_command(pop_pct, notify_pct), 1'b0, '0);
			steady = 1'b0;
		end

		settle();

		$display("ran %0d transactions, %0d samples of which %0d outside the window",
			n_commands, n_samples, n_outside);
		$display("%0d cells queued, %0d dropped on a full queue, %0d popped, %0d silent drains",
			n_queued, n_dropped, n_delivered, n_drained);
		if (mismatches == 0 && verdict_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
